FILE: sv/tlbs_pkg.sv
// Package for the table search block: item field widths, operation codes,
// read address selects and the controller/datapath command and status types.
// No dependencies.
package tlbs_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned SIZE_W  = 8;
    localparam int unsigned PROBE_W = 8;
    localparam int unsigned SDATA_W = 40;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 8'd128;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

    localparam logic [1:0] RD_I   = 2'd0;
    localparam logic [1:0] RD_JM1 = 2'd1;
    localparam logic [1:0] RD_JM2 = 2'd2;
    localparam logic [1:0] RD_MID = 2'd3;

    typedef struct packed {
        logic       start_lin;
        logic       start_bin;
        logic       wr_load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       i_inc;
        logic       j_ld_i;
        logic       ins_ld;
        logic       shift;
        logic       put;
        logic       bs_init;
        logic       mid_ld;
        logic       bs_step;
        logic       probe_inc;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_le1;
        logic i_last;
        logic rd_eq_key;
        logic rd_gt_ins;
        logic j_one;
        logic bs_stop;
    } status_t;

endpackage

FILE: sv/tlbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tlbs_datapath.sv
// Datapath of the table search block: table RAM, index counters, bisection
// bounds, probe counter, size register and result register.
// Depends on tlbs_pkg and tlbs_ram.
module tlbs_datapath #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlbs_pkg::SDATA_W-1:0]  s_tdata,
    input  logic                          cfg_wr_en,
    input  logic [tlbs_pkg::SIZE_W-1:0]   cfg_wr_data,
    output logic [tlbs_pkg::PROBE_W-1:0]  m_tdata,
    input  tlbs_pkg::cmd_t                cmd,
    output tlbs_pkg::status_t             sts
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned NW = (CW > tlbs_pkg::SIZE_W) ? CW : tlbs_pkg::SIZE_W;

    logic [tlbs_pkg::IDX_W-1:0]        in_idx;
    logic signed [tlbs_pkg::VAL_W-1:0] in_val;
    logic signed [tlbs_pkg::VAL_W-1:0] in_key;

    logic [tlbs_pkg::SIZE_W-1:0]       size_reg;
    logic [CW-1:0]                     i_reg, i_next;
    logic [CW-1:0]                     j_reg, j_next;
    logic [CW-1:0]                     lo_reg, lo_next;
    logic [CW-1:0]                     hx_reg, hx_next;
    logic [CW-1:0]                     mid_reg, mid_next;
    logic [CW-1:0]                     probes_reg, probes_next;
    logic signed [tlbs_pkg::VAL_W-1:0] key_reg, key_next;
    logic signed [tlbs_pkg::VAL_W-1:0] ins_reg, ins_next;
    logic [tlbs_pkg::PROBE_W-1:0]      out_reg;

    logic [NW-1:0]                     size_w;
    logic [CW-1:0]                     n_cnt;
    logic [CW-1:0]                     jm1, jm2, mid_p1;
    logic [CW:0]                       mid_sum;
    logic [CW-1:0]                     mid_c;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [tlbs_pkg::VAL_W-1:0]        ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    logic [tlbs_pkg::VAL_W-1:0]        ram_rdata;
    logic signed [tlbs_pkg::VAL_W-1:0] rd_val;

    assign in_idx = s_tdata[tlbs_pkg::IDX_W-1:0];
    assign in_val = s_tdata[tlbs_pkg::IDX_W+tlbs_pkg::VAL_W-1:tlbs_pkg::IDX_W];
    assign in_key = s_tdata[tlbs_pkg::IDX_W+2*tlbs_pkg::VAL_W-1:
                            tlbs_pkg::IDX_W+tlbs_pkg::VAL_W];

    assign size_w = NW'(size_reg);
    assign n_cnt  = (size_w > NW'(DEPTH)) ? CW'(DEPTH) : CW'(size_w);

    assign jm1     = j_reg - CW'(1);
    assign jm2     = j_reg - CW'(2);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hx_reg} - (CW+1)'(1);
    assign mid_c   = mid_sum[CW:1];
    assign mid_p1  = mid_reg + CW'(1);
    assign rd_val  = $signed(ram_rdata);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = j_reg[AW-1:0];
        ram_wdata = ram_rdata;
        if (cmd.wr_load)
        begin
            ram_we    = (32'(in_idx) < 32'(DEPTH));
            ram_waddr = AW'(in_idx);
            ram_wdata = in_val;
        end
        else if (cmd.shift)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.put)
        begin
            ram_we    = 1'b1;
            ram_wdata = ins_reg;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            tlbs_pkg::RD_I:   ram_raddr = i_reg[AW-1:0];
            tlbs_pkg::RD_JM1: ram_raddr = jm1[AW-1:0];
            tlbs_pkg::RD_JM2: ram_raddr = jm2[AW-1:0];
            tlbs_pkg::RD_MID: ram_raddr = mid_c[AW-1:0];
            default:          ram_raddr = i_reg[AW-1:0];
        endcase
    end

    tlbs_ram #(
        .WIDTH (tlbs_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        lo_next     = lo_reg;
        hx_next     = hx_reg;
        mid_next    = mid_reg;
        probes_next = probes_reg;
        key_next    = key_reg;
        ins_next    = ins_reg;
        if (cmd.start_lin || cmd.start_bin)
        begin
            key_next    = in_key;
            probes_next = '0;
            i_next      = cmd.start_bin ? CW'(1) : '0;
        end
        if (cmd.i_inc)
        begin
            i_next = i_reg + CW'(1);
        end
        if (cmd.j_ld_i)
        begin
            j_next = i_reg;
        end
        if (cmd.shift)
        begin
            j_next = jm1;
        end
        if (cmd.ins_ld)
        begin
            ins_next = rd_val;
        end
        if (cmd.bs_init)
        begin
            lo_next     = '0;
            hx_next     = n_cnt;
            probes_next = '0;
        end
        if (cmd.mid_ld)
        begin
            mid_next = mid_c;
        end
        if (cmd.bs_step)
        begin
            if (key_reg > rd_val)
            begin
                lo_next = mid_p1;
            end
            else
            begin
                hx_next = mid_reg;
            end
        end
        if (cmd.probe_inc)
        begin
            probes_next = probes_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hx_reg     <= hx_next;
        mid_reg    <= mid_next;
        probes_reg <= probes_next;
        key_reg    <= key_next;
        ins_reg    <= ins_next;
        if (cmd.out_ld)
        begin
            out_reg <= tlbs_pkg::PROBE_W'(probes_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= tlbs_pkg::TABLE_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    assign sts.n_zero    = (n_cnt == '0);
    assign sts.n_le1     = (n_cnt <= CW'(1));
    assign sts.i_last    = ((i_reg + CW'(1)) == n_cnt);
    assign sts.rd_eq_key = (rd_val == key_reg);
    assign sts.rd_gt_ins = (rd_val > ins_reg);
    assign sts.j_one     = (j_reg == CW'(1));
    assign sts.bs_stop   = (key_reg > rd_val) ? (mid_p1 >= hx_reg) : (lo_reg >= mid_reg);

    assign m_tdata = out_reg;

endmodule

FILE: sv/tlbs_ctrl.sv
// Controller of the table search block: sequences loads, linear search,
// insertion sort and bisection, and owns the input and output handshakes.
// Depends on tlbs_pkg.
module tlbs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tlbs_pkg::OP_W-1:0]  s_op,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output tlbs_pkg::cmd_t             cmd,
    input  tlbs_pkg::status_t          sts
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_L_RD  = 4'd1;
    localparam logic [3:0] ST_L_CMP = 4'd2;
    localparam logic [3:0] ST_S_RDI = 4'd3;
    localparam logic [3:0] ST_S_KEY = 4'd4;
    localparam logic [3:0] ST_S_CMP = 4'd5;
    localparam logic [3:0] ST_S_PUT = 4'd6;
    localparam logic [3:0] ST_B_RD  = 4'd7;
    localparam logic [3:0] ST_B_CMP = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = tlbs_pkg::RD_I;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_op)
                        tlbs_pkg::OP_LOAD:
                        begin
                            cmd.wr_load = 1'b1;
                        end
                        tlbs_pkg::OP_LINEAR:
                        begin
                            cmd.start_lin = 1'b1;
                            state_next    = sts.n_zero ? ST_DONE : ST_L_RD;
                        end
                        tlbs_pkg::OP_BINARY:
                        begin
                            cmd.start_bin = 1'b1;
                            if (sts.n_le1)
                            begin
                                cmd.bs_init = 1'b1;
                                state_next  = sts.n_zero ? ST_DONE : ST_B_RD;
                            end
                            else
                            begin
                                state_next = ST_S_RDI;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_L_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tlbs_pkg::RD_I;
                state_next = ST_L_CMP;
            end
            ST_L_CMP:
            begin
                cmd.probe_inc = 1'b1;
                cmd.i_inc     = 1'b1;
                state_next    = (sts.rd_eq_key || sts.i_last) ? ST_DONE : ST_L_RD;
            end
            ST_S_RDI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tlbs_pkg::RD_I;
                cmd.j_ld_i = 1'b1;
                state_next = ST_S_KEY;
            end
            ST_S_KEY:
            begin
                cmd.ins_ld = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tlbs_pkg::RD_JM1;
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                if (sts.rd_gt_ins)
                begin
                    cmd.shift = 1'b1;
                    if (sts.j_one)
                    begin
                        state_next = ST_S_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = tlbs_pkg::RD_JM2;
                    end
                end
                else
                begin
                    state_next = ST_S_PUT;
                end
            end
            ST_S_PUT:
            begin
                cmd.put   = 1'b1;
                cmd.i_inc = 1'b1;
                if (sts.i_last)
                begin
                    cmd.bs_init = 1'b1;
                    state_next  = ST_B_RD;
                end
                else
                begin
                    state_next = ST_S_RDI;
                end
            end
            ST_B_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tlbs_pkg::RD_MID;
                cmd.mid_ld = 1'b1;
                state_next = ST_B_CMP;
            end
            ST_B_CMP:
            begin
                cmd.probe_inc = 1'b1;
                cmd.bs_step   = 1'b1;
                state_next    = (sts.rd_eq_key || sts.bs_stop) ? ST_DONE : ST_B_RD;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_ld)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: sv/table_linear_binary_search_top.sv
// Load writes one table entry when accepted. Linear search reads and compares one entry
// per probe, n = used entries. Binary search first sorts the table in place by insertion
// sort (read the entry, load it and read its neighbour, compare and shift, put it back);
// bisection then reads and compares the middle entry per probe.
// One item is in work at a time; a finished result waits in an output register.
// Reset clears control state and sets table_size to 128; table contents are kept.
module table_linear_binary_search_top #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[6:0], entry_value[22:7], search_key[38:23], zero pad [39]
    input  logic [tlbs_pkg::SDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [tlbs_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // probe_count[7:0]
    output logic [tlbs_pkg::PROBE_W-1:0]  m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [tlbs_pkg::SIZE_W-1:0]   cfg_wr_data
);

    tlbs_pkg::cmd_t    cmd;
    tlbs_pkg::status_t sts;

    tlbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tlbs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
